// ----- rtl/tbim_pkg.sv -----
// tbim_pkg: widths, stage and result types of the triangular block index map
// no dependencies; imported by every module of the block
`default_nettype none

package tbim_pkg;

    // index bits taken from the input field
    localparam int INDEX_WIDTH     = 32;
    localparam int IN_WIDTH        = 32;
    localparam int FIELD_WIDTH     = 17;

    // radicand 8*index+1, padded to whole bit pairs
    localparam int MAP_WIDTH       = INDEX_WIDTH + 3;
    localparam int ROOT_WIDTH      = (MAP_WIDTH + 1) / 2;
    localparam int RAD_WIDTH       = 2 * ROOT_WIDTH;
    localparam int REM_WIDTH       = ROOT_WIDTH + 1;
    localparam int SHIFT_WIDTH     = REM_WIDTH + 2;
    localparam int BLK_WIDTH       = ROOT_WIDTH - 1;
    localparam int DIFF_WIDTH      = ROOT_WIDTH + 2;

    // stream widths, rounded up to whole bytes
    localparam int IN_TDATA_WIDTH  = ((IN_WIDTH + 7) / 8) * 8;
    localparam int RES_WIDTH       = 2 * FIELD_WIDTH;
    localparam int OUT_TDATA_WIDTH = ((RES_WIDTH + 7) / 8) * 8;

    // one stage of the digit-by-digit square root
    typedef struct packed {
        logic                   valid;
        logic [REM_WIDTH-1:0]   rem;
        logic [ROOT_WIDTH-1:0]  root;
        logic [RAD_WIDTH-1:0]   rad;
    } t_root_stage;

    // result item, block number in the low bits
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] offset_in_block;
        logic [FIELD_WIDTH-1:0] block_number;
    } t_result;

    // first stage contents for a fresh index
    function automatic t_root_stage start_stage(logic valid, logic [IN_WIDTH-1:0] idx);
        t_root_stage s;
        logic [INDEX_WIDTH-1:0] n;
        n       = INDEX_WIDTH'(idx);
        s.valid = valid;
        s.rem   = '0;
        s.root  = '0;
        s.rad   = RAD_WIDTH'({n, 3'b001});
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/triangular_block_index_map.sv -----
// triangular_block_index_map: top level, square root pipeline and output buffer
// depends on tbim_pkg, tbim_root_stage, tbim_offset_stage, tbim_out_skid
//
// Maps a flat element index into an array of blocks of sizes 1, 2, 3 and so
// on, giving the block number k (largest k with k(k+1)/2 <= index) and the
// offset inside that block.
// Input channel s_axis: one transaction carries element_index in tdata.
// Output channel m_axis: one transaction per input, block_number in the low
// 17 bits of tdata and offset_in_block in the next 17.
// The root of 8*index+1 is found exactly, one bit per pipeline stage: 18
// root stages, then one offset stage and the output register.
// Throughput is one transaction per cycle unless the receiver stalls;
// all stages share one enable.
// When the receiver stalls, one result goes to a skid entry and the whole
// pipeline then holds; s_axis_tready falls in the cycle after, and nothing
// is lost or repeated.
// Synchronous reset empties the pipeline; there is no other state.
`default_nettype none

module triangular_block_index_map (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // element_index[31:0]
    input  wire  [tbim_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // block_number[16:0], offset_in_block[33:17], zero fill [39:34]
    output logic [tbim_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
    import tbim_pkg::*;

    t_root_stage w_stage [0:ROOT_WIDTH];
    logic        w_en;
    logic        w_push;
    t_result     w_result;

    assign s_axis_tready = w_en;

    // fresh item enters the first root stage
    assign w_stage[0] = start_stage(s_axis_tvalid, IN_WIDTH'(s_axis_tdata));

    // one root bit per stage
    for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_root
        tbim_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    tbim_offset_stage u_offset (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_stage  (w_stage[ROOT_WIDTH]),
        .o_valid  (w_push),
        .o_result (w_result)
    );

    // push only on a move of the pipeline
    tbim_out_skid u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (w_push && w_en),
        .i_result      (w_result),
        .o_ready       (w_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/tbim_root_stage.sv -----
// tbim_root_stage: one registered digit step of the integer square root
// depends on tbim_pkg
`default_nettype none

module tbim_root_stage (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  tbim_pkg::t_root_stage i_stage,
    output tbim_pkg::t_root_stage o_stage
);
    import tbim_pkg::*;

    t_root_stage            r_stage;
    t_root_stage            n_stage;
    logic [SHIFT_WIDTH-1:0] w_rem_sh;
    logic [SHIFT_WIDTH-1:0] w_trial;
    logic                   w_take;

    // bring down the next bit pair and try root*4+1
    always_comb begin
        w_rem_sh = {i_stage.rem, i_stage.rad[RAD_WIDTH-1 -: 2]};
        w_trial  = {1'b0, i_stage.root, 2'b01};
        w_take   = (w_rem_sh >= w_trial);
        n_stage.valid = i_stage.valid;
        n_stage.rem   = w_take ? REM_WIDTH'(w_rem_sh - w_trial) : REM_WIDTH'(w_rem_sh);
        n_stage.root  = {i_stage.root[ROOT_WIDTH-2:0], w_take};
        n_stage.rad   = {i_stage.rad[RAD_WIDTH-3:0], 2'b00};
    end

    // valid is control, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= n_stage.valid;
        end
        if (i_en) begin
            r_stage.rem  <= n_stage.rem;
            r_stage.root <= n_stage.root;
            r_stage.rad  <= n_stage.rad;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

// ----- rtl/tbim_offset_stage.sv -----
// tbim_offset_stage: turns root and remainder into block number and offset
// depends on tbim_pkg
`default_nettype none

module tbim_offset_stage (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  tbim_pkg::t_root_stage i_stage,
    output logic                  o_valid,
    output tbim_pkg::t_result     o_result
);
    import tbim_pkg::*;

    logic                  r_valid;
    t_result               r_result;
    t_result               n_result;
    logic [BLK_WIDTH-1:0]  w_half;
    logic [BLK_WIDTH-1:0]  w_block;
    logic [DIFF_WIDTH-1:0] w_rem_ext;
    logic [DIFF_WIDTH-1:0] w_adj;
    logic [DIFF_WIDTH-1:0] w_diff;

    // odd root r = 2k+1 leaves 8*offset; even root r = 2k+2 leaves 8*offset-2r+1
    always_comb begin
        w_half    = i_stage.root[ROOT_WIDTH-1:1];
        w_rem_ext = DIFF_WIDTH'(i_stage.rem);
        w_adj     = w_rem_ext + DIFF_WIDTH'({i_stage.root, 1'b0}) - DIFF_WIDTH'(1);
        if (i_stage.root[0]) begin
            w_block = w_half;
            w_diff  = w_rem_ext;
        end else begin
            w_block = w_half - BLK_WIDTH'(1);
            w_diff  = w_adj;
        end
        n_result.block_number    = FIELD_WIDTH'(w_block);
        n_result.offset_in_block = FIELD_WIDTH'(w_diff[DIFF_WIDTH-1:3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
        end
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/tbim_out_skid.sv -----
// tbim_out_skid: output register with one skid entry, holds the pipeline on stall
// depends on tbim_pkg
`default_nettype none

module tbim_out_skid (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_push,
    input  tbim_pkg::t_result                    i_result,
    output logic                                 o_ready,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // block_number[16:0], offset_in_block[33:17], zero fill [39:34]
    output logic [tbim_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
    import tbim_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    // pipeline moves only while the skid entry is free
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload follows the same choice
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_WIDTH'(r_out);

endmodule

`default_nettype wire

// ----- rtl/tbim_checker.sv -----
// tbim_checker: port-level assertions for triangular_block_index_map
// depends on tbim_pkg; bound to the top level below
`default_nettype none

module tbim_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 s_axis_tready,
    input wire                                 m_axis_tvalid,
    input wire                                 m_axis_tready,
    input wire [tbim_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
    import tbim_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // offset never exceeds the block number
    a_offset_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        m_axis_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH] <= m_axis_tdata[FIELD_WIDTH-1:0])
        else $error("offset beyond block");

    // reset empties the output and opens the input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("state left after reset");

    // no result is offered straight out of reset
    a_no_invention: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result without input");

endmodule

bind triangular_block_index_map tbim_checker u_tbim_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/triangular_block_index_map_tb.sv -----
// triangular_block_index_map_tb: self-checking testbench for the index map
// depends on tbim_pkg and triangular_block_index_map; stream driver and
// monitor with a bit-search predictor of block number and offset
`timescale 1ns / 1ps

module triangular_block_index_map_tb;

    import tbim_pkg::*;

    localparam int    CLK_HALF       = 6;
    localparam int    RESET_CYCLES   = 12;
    localparam int    RANDOM_ITEMS   = 1050;
    localparam int    PIPE_LATENCY   = 20;
    localparam int    HOLDOFF_AT     = 820;
    localparam int    HOLDOFF_CYCLES = 150;
    localparam longint TIMEOUT_NS    = 64'd200_000 * 2 * CLK_HALF;

    // traffic profiles: who idles and how often
    typedef enum logic [1:0] {
        PHASE_RX_STALLS,
        PHASE_TX_GAPS,
        PHASE_FREE_RUN
    } t_traffic_phase;

    typedef struct {
        logic [IN_WIDTH-1:0] idx;
        t_traffic_phase      phase;
        bit                  drain_first;
    } t_pending_index;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata;

    t_pending_index pending_indices[$];
    t_result        expected_maps[$];
    t_traffic_phase traffic_phase  = PHASE_RX_STALLS;
    int             accepted_count = 0;
    int             holdoff_left   = 0;
    bit             holdoff_done   = 1'b0;
    int             fail_count     = 0;

    triangular_block_index_map i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // k(k+1)/2, exact for k below 2^32
    function automatic logic [63:0] triangle(logic [63:0] k);
        return (k * (k + 64'd1)) >> 1;
    endfunction

    // largest k with triangle(k) <= index, then the offset into block k
    function automatic t_result map_index(logic [IN_WIDTH-1:0] idx);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] cand;
        t_result     r;
        n = 64'(idx);
        k = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = k | (64'd1 << b);
            if (triangle(cand) <= n) begin
                k = cand;
            end
        end
        r.block_number    = k[FIELD_WIDTH-1:0];
        r.offset_in_block = FIELD_WIDTH'(n - triangle(k));
        return r;
    endfunction

    // mix of full-range, small, near-boundary, near-top and power-of-two indices
    function automatic logic [IN_WIDTH-1:0] random_index();
        logic [63:0] v;
        int unsigned k;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 1000);
            2: begin
                k = $urandom_range(0, 92681);
                v = triangle(64'(k)) + 64'($urandom_range(0, k + 1)) - 64'd1;
                return (v > 64'hFFFF_FFFF) ? $urandom : v[IN_WIDTH-1:0];
            end
            3: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
        endcase
    endfunction

    // driver: offers pending indices, predicts on each accepted transaction
    always @(posedge i_clk) begin
        t_pending_index item;
        int             idle_pct;
        bit             gap;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_maps.push_back(map_index(s_axis_tdata[IN_WIDTH-1:0]));
                accepted_count <= accepted_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                idle_pct = 0;
                if (pending_indices.size() != 0) begin
                    idle_pct = (pending_indices[0].phase == PHASE_RX_STALLS) ? 6 :
                               (pending_indices[0].phase == PHASE_TX_GAPS)   ? 68 : 0;
                end
                gap = $urandom_range(0, 99) < idle_pct;
                if (pending_indices.size() != 0 && !gap &&
                    !(pending_indices[0].drain_first && expected_maps.size() != 0)) begin
                    item = pending_indices.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.idx;
                    traffic_phase <= item.phase;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && accepted_count >= HOLDOFF_AT) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end
    end

    // monitor: checks each result transaction, then paces tready
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        int      idle_pct;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[RES_WIDTH-1:0]);
                if (expected_maps.size() == 0) begin
                    $display("%0t: unexpected result block %0d offset %0d",
                             $time, got.block_number, got.offset_in_block);
                    fail_count++;
                end else begin
                    want = expected_maps.pop_front();
                    if (got.block_number !== want.block_number) begin
                        $display("%0t: block_number expected %0d actual %0d",
                                 $time, want.block_number, got.block_number);
                        fail_count++;
                    end
                    if (got.offset_in_block !== want.offset_in_block) begin
                        $display("%0t: offset_in_block expected %0d actual %0d",
                                 $time, want.offset_in_block, got.offset_in_block);
                        fail_count++;
                    end
                end
            end
            idle_pct = (traffic_phase == PHASE_RX_STALLS) ? 68 :
                       (traffic_phase == PHASE_TX_GAPS)   ? 6 : 0;
            m_axis_tready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [IN_WIDTH-1:0] directed[$];
        t_traffic_phase      ph;
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd5, 32'd6, 32'd9, 32'd10,
                     32'(triangle(64'd65535)), 32'(triangle(64'd65536) - 64'd1),
                     32'(triangle(64'd92681) - 64'd1), 32'(triangle(64'd92681)),
                     32'h1FFF_FFFF, 32'h2000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        foreach (directed[i]) begin
            pending_indices.push_back('{directed[i], PHASE_RX_STALLS, 1'b0});
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            ph = (i < RANDOM_ITEMS / 3)     ? PHASE_RX_STALLS :
                 (i < 2 * RANDOM_ITEMS / 3) ? PHASE_TX_GAPS : PHASE_FREE_RUN;
            pending_indices.push_back('{random_index(), ph,
                                        (i == RANDOM_ITEMS / 3) || (i == 2 * RANDOM_ITEMS / 3)});
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_indices.size() != 0 || s_axis_tvalid || expected_maps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, expected_maps.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tbim_pkg.sv
rtl/tbim_root_stage.sv
rtl/tbim_offset_stage.sv
rtl/tbim_out_skid.sv
rtl/triangular_block_index_map.sv
rtl/tbim_checker.sv
tb/triangular_block_index_map_tb.sv
